// ===== hw/rtl/wbss_pkg.sv =====
package wbss_pkg;

  // sizing
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int POSITION_BITS     = 32;
  localparam int OFFSET_W          = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_LEN_W         = 5;
  localparam int CFG_WILD_W        = 16;
  localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int SEL_W             = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;

  typedef logic [7:0] byte_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OFFSET_W-1:0] offset_t;

  // signature as seen by the cell row
  typedef struct packed {
    byte_t [MAX_PATTERN_BYTES-1:0] sig;
    logic  [MAX_PATTERN_BYTES-1:0] wild;
    logic  [LEN_W-1:0]             len_eff;
  } sig_cfg_t;

  // per-beat control shared by all cells
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/wbss_in_if.sv =====
interface wbss_in_if;
  import wbss_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/wbss_out_if.sv =====
interface wbss_out_if;
  import wbss_pkg::*;

  logic    valid;
  logic    ready;
  offset_t match_offset;

  modport source (output valid, output match_offset, input ready);
  modport sink   (input valid, input match_offset, output ready);
endinterface

// ===== hw/rtl/wildcard_byte_signature_scan.sv =====
// Scans a byte stream one beat per clock for a signature of 1 to 16 bytes, where any signature
// byte flagged in the wildcard mask matches every data byte, and returns the buffer offset of
// the first byte of each match (overlapping matches included); a beat carries at most one
// result, produced in the cycle of its acceptance and registered in the output register, or in
// the skid entry if a result still waits there. A row of 16 cells, one per signature position,
// holds the partial-match bits and shifts them forward on every beat, so the input takes one
// byte each clock; a two-entry output stage lets input continue while a result waits, and the
// input stalls only when both entries are full. The beat flagged last_byte is scanned normally
// and then clears the partial matches and the offset counter, which otherwise saturates at its
// maximum. Write the configuration registers only while no beat is in flight; pattern_length
// of zero never matches and values above 16 act as 16.
module wildcard_byte_signature_scan
  import wbss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wbss_in_if.sink               in_chan,
  wbss_out_if.source            out_chan
);

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

  sig_cfg_t                     sig_cfg;
  cell_ctl_t                    ctl;
  logic [MAX_PATTERN_BYTES-1:0] part_r;
  logic [MAX_PATTERN_BYTES-1:0] part_nxt;
  logic [MAX_PATTERN_BYTES-1:0] prev_part;
  logic [MAX_PATTERN_BYTES-1:0] in_use;
  logic                         accept;
  logic                         hit;
  logic [LEN_W-1:0]             len_m1;
  logic [SEL_W-1:0]             sel;
  offset_t                      start_off;
  pos_t                         pos_r;
  pos_t                         pos_nxt;
  logic                         out_valid_r;
  offset_t                      out_off_r;
  logic                         skid_valid_r;
  offset_t                      skid_off_r;
  logic                         pop;
  logic                         push;

  // configuration registers
  wbss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sig_cfg   (sig_cfg)
  );

  // handshake
  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign ctl.advance   = accept;
  assign ctl.clear     = in_chan.last_byte;

  // cell row, each cell after the first fed by its left neighbor
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_part[k] = 1'b1;
    end else begin : g_rest
      assign prev_part[k] = part_r[k-1];
    end
    assign in_use[k] = (LEN_W'(k) < sig_cfg.len_eff);

    wbss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_part (prev_part[k]),
      .data_byte (in_chan.data_byte),
      .sig_byte  (sig_cfg.sig[k]),
      .wild      (sig_cfg.wild[k]),
      .in_use    (in_use[k]),
      .part_nxt  (part_nxt[k]),
      .part_r    (part_r[k])
    );
  end

  // full match at the last used position
  assign len_m1    = sig_cfg.len_eff - LEN_W'(1);
  assign sel       = len_m1[SEL_W-1:0];
  assign hit       = (sig_cfg.len_eff != '0) && part_nxt[sel];
  assign start_off = OFFSET_W'(pos_r - POSITION_BITS'(len_m1));
  assign push      = accept && hit;
  assign pop       = out_valid_r && out_chan.ready;

  // offset counter, saturating, cleared after the last byte
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_chan.last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_off_r <= skid_off_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_off_r <= start_off;
      end else begin
        skid_off_r <= start_off;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.match_offset = out_off_r;

`ifndef ASSERT_OFF
  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output entry");

  // end of buffer clears counter and partial matches
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.last_byte) |=> (pos_r == '0) && (part_r == '0))
    else $error("last byte did not clear scan state");

  // counter advances by one below saturation
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_chan.last_byte && pos_r != POS_MAX) |=> pos_r == $past(pos_r) + POSITION_BITS'(1))
    else $error("offset counter did not advance");

  // no partial match survives beyond the signature length
  a_part_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (part_r & ~$past(in_use)) == '0)
    else $error("partial match beyond signature length");

  // a result beat is never dropped while both entries are full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && skid_valid_r) |-> !accept)
    else $error("input accepted with both output entries full");
`endif

endmodule

// ===== hw/rtl/wbss_cfg.sv =====
module wbss_cfg
  import wbss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sig_cfg_t              sig_cfg
);

  logic [63:0]           pat_lo_r;
  logic [63:0]           pat_hi_r;
  logic [CFG_WILD_W-1:0] wild_r;
  logic [CFG_LEN_W-1:0]  len_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      wild_r   <= '0;
      len_r    <= CFG_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pat_lo_r <= cfg_data[63:0];
        CFG_PATTERN_HIGH:   pat_hi_r <= cfg_data[63:0];
        CFG_WILDCARD_MASK:  wild_r   <= cfg_data[CFG_WILD_W-1:0];
        CFG_PATTERN_LENGTH: len_r    <= cfg_data[CFG_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // spread bytes over signature positions, unused positions read as zero
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_pos
    if (k < 8) begin : g_lo
      assign sig_cfg.sig[k]  = pat_lo_r[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign sig_cfg.sig[k]  = pat_hi_r[8*(k-8) +: 8];
    end else begin : g_none
      assign sig_cfg.sig[k]  = '0;
    end
    if (k < CFG_WILD_W) begin : g_wild
      assign sig_cfg.wild[k] = wild_r[k];
    end else begin : g_nowild
      assign sig_cfg.wild[k] = 1'b0;
    end
  end

  // clamp length to the cell count
  always_comb begin
    if (int'(len_r) > MAX_PATTERN_BYTES) begin
      sig_cfg.len_eff = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      sig_cfg.len_eff = LEN_W'(len_r);
    end
  end

endmodule

// ===== hw/rtl/wbss_cell.sv =====
module wbss_cell
  import wbss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      prev_part,
  input  byte_t     data_byte,
  input  byte_t     sig_byte,
  input  logic      wild,
  input  logic      in_use,
  output logic      part_nxt,
  output logic      part_r
);

  // this position matches if the previous one did and the byte fits
  assign part_nxt = prev_part & in_use & (wild | (sig_byte == data_byte));

  // hold the partial-match bit, cleared at end of buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= 1'b0;
    end else if (ctl.advance) begin
      part_r <= ctl.clear ? 1'b0 : part_nxt;
    end
  end

endmodule
